FILE: hw/rtl/iirsv_pkg.sv
// Shared types and constants for the IIR filter with loadable start values.
// Depends on nothing; imported by every RTL file of the block.
package iirsv_pkg;

    localparam int IIRSV_FORWARD_TAPS  = 4;
    localparam int IIRSV_FEEDBACK_TAPS = 3;

    localparam int DATA_W  = 16;
    localparam int CIDX_W  = 3;
    localparam int TAPSU_W = 3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_COEF_B0   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_COEF_B1   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_COEF_B2   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_COEF_B3   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_COEF_A0   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_COEF_A1   = 3'd5;
    localparam logic [CIDX_W-1:0] REG_COEF_A2   = 3'd6;
    localparam logic [CIDX_W-1:0] REG_TAPS_USED = 3'd7;

    localparam int NUM_B_REGS = 4;
    localparam int NUM_A_REGS = 3;

    localparam logic signed [DATA_W-1:0] COEF_UNITY     = 16'sd4096;
    localparam logic [TAPSU_W-1:0]       TAPS_USED_INIT = 3'd1;

    localparam logic CMD_LOAD_START = 1'b0;
    localparam logic CMD_SAMPLE     = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_out;
        logic                     saturated;
        logic                     div_error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MAC,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/iir_filter_with_start_values_top.sv
// Top level of the direct-form-I IIR filter with loadable feedback start values.
// Depends on iirsv_pkg and iirsv_divider.
//
// Each sample is handled by one shared 16x16 multiplier that walks the forward
// and feedback taps (one term per cycle into a wide accumulator), then a serial
// divider that removes a0 at one quotient bit per cycle. The accumulator is 35
// bits wide with the default taps. A start value or a warm-up sample skips the
// multiplier and the divider, and so does a sample that meets a zero a0. The
// input is not ready while a sample is in flight; a finished result sits in an
// output register, so the next transaction can be accepted before it is taken. A
// new result waits while that register still holds one that has not been taken.
module iir_filter_with_start_values_top #(
    parameter int FORWARD_TAPS  = iirsv_pkg::IIRSV_FORWARD_TAPS,
    parameter int FEEDBACK_TAPS = iirsv_pkg::IIRSV_FEEDBACK_TAPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  iirsv_pkg::sample_t            sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output iirsv_pkg::result_t            result,
    input  logic                          cfg_wr_en,
    input  logic [iirsv_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [iirsv_pkg::DATA_W-1:0]  cfg_data
);
    import iirsv_pkg::*;

    localparam int NT    = FORWARD_TAPS + FEEDBACK_TAPS - 1;
    localparam int TW    = (NT > 1) ? $clog2(NT) : 1;
    localparam int ACC_W = 32 + ((NT > 1) ? $clog2(NT) : 0);
    localparam int DL    = (FORWARD_TAPS > 1) ? FORWARD_TAPS - 1 : 1;
    localparam int HL    = (FEEDBACK_TAPS > 1) ? FEEDBACK_TAPS - 1 : 1;
    localparam int WW    = (FORWARD_TAPS > 1) ? $clog2(FORWARD_TAPS) : 1;

    // configuration
    logic signed [DATA_W-1:0] coef_b_reg [FORWARD_TAPS];
    logic signed [DATA_W-1:0] coef_a_reg [FEEDBACK_TAPS];
    logic [TAPSU_W-1:0]       taps_used_reg;

    // filter state
    logic signed [DATA_W-1:0] dly_reg  [DL];
    logic signed [DATA_W-1:0] hist_reg [HL];
    logic [WW-1:0]            warm_reg;

    state_t state_reg, state_next;

    logic                     cmd_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic                     err_reg;
    logic                     neg_reg;
    logic [TW-1:0]            term_reg;
    logic signed [31:0]       prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    result_t                  out_reg;

    // sequencer outputs
    logic take;
    logic a0_zero;
    logic in_warmup;
    logic load_start;
    logic err_set;
    logic warm_shift;
    logic mac_begin;
    logic mul_en;
    logic div_start;
    logic res_load;
    logic term_last;

    logic [3:0]               taps;
    logic signed [DATA_W-1:0] coef_sel;
    logic signed [DATA_W-1:0] samp_sel;
    logic                     term_en;
    logic                     term_sub;

    logic [ACC_W-1:0]         acc_mag;
    logic [DATA_W-1:0]        a0_mag;
    logic                     div_done;
    logic [ACC_W-1:0]         q_mag;
    logic signed [DATA_W-1:0] y_val;
    logic                     sat_val;

    logic                     hist_shift;
    logic signed [DATA_W-1:0] hist_in;
    logic                     dly_shift;

    always_comb
    begin
        if (taps_used_reg == '0)
        begin
            taps = 4'd1;
        end
        else if (32'(taps_used_reg) > FORWARD_TAPS)
        begin
            taps = 4'(FORWARD_TAPS);
        end
        else
        begin
            taps = {1'b0, taps_used_reg};
        end
    end

    assign take      = sample_valid & sample_ready;
    assign a0_zero   = (coef_a_reg[0] == '0);
    assign in_warmup = ((5'(warm_reg) + 5'd1) < {1'b0, taps});
    assign term_last = (term_reg == TW'(NT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (cmd_reg == CMD_LOAD_START)
                begin
                    state_next = ST_IDLE;
                end
                else if (a0_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (in_warmup)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (term_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_ready = 1'b0;
        load_start   = 1'b0;
        err_set      = 1'b0;
        warm_shift   = 1'b0;
        mac_begin    = 1'b0;
        mul_en       = 1'b0;
        div_start    = 1'b0;
        res_load     = 1'b0;
        case (state_reg)
            ST_IDLE:   sample_ready = 1'b1;
            ST_EVAL:
            begin
                load_start = (cmd_reg == CMD_LOAD_START);
                err_set    = (cmd_reg == CMD_SAMPLE) && a0_zero;
                warm_shift = (cmd_reg == CMD_SAMPLE) && !a0_zero && in_warmup;
                mac_begin  = (cmd_reg == CMD_SAMPLE) && !a0_zero && !in_warmup;
            end
            ST_MAC:    mul_en    = 1'b1;
            ST_DIV_GO: div_start = 1'b1;
            ST_DONE:   res_load  = !out_valid_reg || result_ready;
            default:   sample_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FORWARD_TAPS; k++)
            begin
                coef_b_reg[k] <= (k == 0) ? COEF_UNITY : '0;
            end
            for (int k = 0; k < FEEDBACK_TAPS; k++)
            begin
                coef_a_reg[k] <= (k == 0) ? COEF_UNITY : '0;
            end
            taps_used_reg <= TAPS_USED_INIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_B3:
                begin
                    for (int k = 0; k < FORWARD_TAPS; k++)
                    begin
                        if (k < NUM_B_REGS && cfg_index == (REG_COEF_B0 + CIDX_W'(k)))
                        begin
                            coef_b_reg[k] <= cfg_data;
                        end
                    end
                end
                REG_COEF_A0, REG_COEF_A1, REG_COEF_A2:
                begin
                    for (int k = 0; k < FEEDBACK_TAPS; k++)
                    begin
                        if (k < NUM_A_REGS && cfg_index == (REG_COEF_A0 + CIDX_W'(k)))
                        begin
                            coef_a_reg[k] <= cfg_data;
                        end
                    end
                end
                REG_TAPS_USED: taps_used_reg <= cfg_data[TAPSU_W-1:0];
                default:       taps_used_reg <= taps_used_reg;
            endcase
        end
    end

    // transaction capture and per-item flags
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= sample.command;
            x_reg   <= sample.value;
        end
        if (state_reg == ST_EVAL)
        begin
            err_reg <= err_set;
        end
        if (div_start)
        begin
            neg_reg <= acc_reg[ACC_W-1] ^ coef_a_reg[0][DATA_W-1];
        end
    end

    // term select for the shared multiplier
    always_comb
    begin
        coef_sel = coef_b_reg[0];
        samp_sel = x_reg;
        term_en  = 1'b1;
        term_sub = 1'b0;
        for (int k = 1; k < FORWARD_TAPS; k++)
        begin
            if (term_reg == TW'(k))
            begin
                coef_sel = coef_b_reg[k];
                samp_sel = dly_reg[k-1];
                term_en  = (5'(k) < {1'b0, taps});
            end
        end
        for (int k = 1; k < FEEDBACK_TAPS; k++)
        begin
            if (term_reg == TW'(FORWARD_TAPS + k - 1))
            begin
                coef_sel = coef_a_reg[k];
                samp_sel = hist_reg[k-1];
                term_en  = 1'b1;
                term_sub = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            term_reg     <= '0;
        end
        else
        begin
            prod_vld_reg <= mul_en & term_en;
            if (mac_begin)
            begin
                term_reg <= '0;
            end
            else if (mul_en)
            begin
                term_reg <= term_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= coef_sel * samp_sel;
        prod_sub_reg <= term_sub;
        if (mac_begin)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= prod_sub_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign a0_mag  = coef_a_reg[0][DATA_W-1] ? DATA_W'(-coef_a_reg[0])
                                             : DATA_W'(coef_a_reg[0]);

    iirsv_divider #(
        .ACC_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (a0_mag),
        .done     (div_done),
        .quotient (q_mag)
    );

    // sign and clip the truncated quotient
    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = (|q_mag[ACC_W-1:DATA_W]) || (q_mag[DATA_W-1] && (|q_mag[DATA_W-2:0]));
            y_val   = sat_val ? 16'sh8000 : DATA_W'(-q_mag[DATA_W-1:0]);
        end
        else
        begin
            sat_val = |q_mag[ACC_W-1:DATA_W-1];
            y_val   = sat_val ? 16'sh7fff : q_mag[DATA_W-1:0];
        end
    end

    assign dly_shift  = warm_shift || (res_load && !err_reg);
    assign hist_shift = load_start || (res_load && !err_reg);
    assign hist_in    = load_start ? x_reg : y_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DL; k++)
            begin
                dly_reg[k] <= '0;
            end
            for (int k = 0; k < HL; k++)
            begin
                hist_reg[k] <= '0;
            end
            warm_reg <= '0;
        end
        else
        begin
            if (dly_shift && FORWARD_TAPS > 1)
            begin
                dly_reg[0] <= x_reg;
                for (int k = 1; k < DL; k++)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
            if (hist_shift && FEEDBACK_TAPS > 1)
            begin
                hist_reg[0] <= hist_in;
                for (int k = 1; k < HL; k++)
                begin
                    hist_reg[k] <= hist_reg[k-1];
                end
            end
            if (load_start)
            begin
                warm_reg <= '0;
            end
            else if (warm_shift)
            begin
                warm_reg <= warm_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (err_reg)
            begin
                out_reg.y_out     <= '0;
                out_reg.saturated <= 1'b0;
                out_reg.div_error <= 1'b1;
            end
            else
            begin
                out_reg.y_out     <= y_val;
                out_reg.saturated <= sat_val;
                out_reg.div_error <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hw/rtl/iirsv_divider.sv
// Serial restoring divider: unsigned magnitudes, one quotient bit per cycle.
// Depends on iirsv_pkg for the data width.
module iirsv_divider #(
    parameter int ACC_W = 35
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ACC_W-1:0]              dividend,
    input  logic [iirsv_pkg::DATA_W-1:0]  divisor,
    output logic                          done,
    output logic [ACC_W-1:0]              quotient
);
    import iirsv_pkg::*;

    localparam int CNT_W = (ACC_W > 1) ? $clog2(ACC_W) : 1;

    logic [ACC_W-1:0]  dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              qbit;

    // remainder stays below the divisor, so it fits DATA_W bits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[ACC_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        qbit  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], qbit};
            rem_reg <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: hw/rtl/iirsv_checker.sv
// Port-level checks for the IIR filter top level, bound to it below.
// Depends on iirsv_pkg and iir_filter_with_start_values_top.
module iirsv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input iirsv_pkg::result_t            result
);
    import iirsv_pkg::*;

    // every accepted transaction takes the input out of ready while the filter evaluates it
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("input ready right after a transaction");

    a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.div_error |-> result.y_out == '0 && !result.saturated)
        else $error("divide error result carries data");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.y_out == 16'sh7fff || result.y_out == 16'sh8000)
        else $error("saturated flag without a clipped value");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind iir_filter_with_start_values_top iirsv_checker u_iirsv_checker (.*);
